@@ rtl/core/tagged_deque_with_positional_remove_assert.svh @@
// assertion macros for the tagged deque checker
`ifndef TAGGED_DEQUE_WITH_POSITIONAL_REMOVE_ASSERT_SVH
`define TAGGED_DEQUE_WITH_POSITIONAL_REMOVE_ASSERT_SVH

// property must hold at every clock edge outside reset
`define TDQ_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define TDQ_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ rtl/core/tdq_pkg.sv @@
// shared types and codes for the tagged deque
package tdq_pkg;

	localparam logic [2:0] FN_QUERY     = 3'd0;
	localparam logic [2:0] FN_PUSH_TAIL = 3'd1;
	localparam logic [2:0] FN_PUSH_HEAD = 3'd2;
	localparam logic [2:0] FN_POP       = 3'd3;
	localparam logic [2:0] FN_REMOVE    = 3'd4;
	localparam logic [2:0] FN_CLEAR     = 3'd5;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_BADPOS = 2'd3;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] item_data;
		logic [15:0] item_id;
		logic [8:0]  position;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        removed_valid;
		logic [31:0] removed_data;
		logic [15:0] removed_id;
		logic        head_valid;
		logic [31:0] head_data;
		logic        head_id_match;
		logic [8:0]  length;
	} out_t;

	typedef enum logic [1:0] {RD_HEAD, RD_POS, RD_SHIFT} rd_sel_t;
	typedef enum logic [1:0] {WR_NONE, WR_TAIL, WR_HEAD, WR_SHIFT} wr_sel_t;
	typedef enum logic [1:0] {HEAD_KEEP, HEAD_DEC, HEAD_INC, HEAD_ZERO} head_op_t;
	typedef enum logic [1:0] {CNT_KEEP, CNT_INC, CNT_DEC, CNT_ZERO} cnt_op_t;

	typedef struct packed {
		logic       load_item;
		rd_sel_t    rd_sel;
		wr_sel_t    wr_sel;
		head_op_t   head_op;
		cnt_op_t    cnt_op;
		logic       idx_init;
		logic       idx_inc;
		logic       set_status;
		logic [1:0] status;
		logic       cap_removed;
		logic       load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] func;
		logic       full;
		logic       empty;
		logic       pos_bad;
		logic       shift_more;
		logic       shift_more_next;
	} dp_sts_t;

endpackage

@@ rtl/core/tagged_deque_with_positional_remove.sv @@
// top level: bounded tagged deque with push, pop, positional remove and clear
//
// Input channel (in_valid/in_ready/in_word) takes one operation word: query,
// push tail, push head, pop head, remove at a 1-based position, or clear.
// Output channel (out_valid/out_ready/out_word) gives exactly one result word
// per operation: status, removed entry, head entry, head id match, length.
// Entries live in a DEPTH-deep single-port-write memory with a registered read.
// Query, clear and refused ops go from execution to the result register.
// A push, pop or remove reads the new head before finishing; a pop and a
// remove first capture the entry, and the remove's shift loop does one read
// and one write per moved entry through the single memory port pair.
// A new word is taken in the cycle after the previous result is registered.
// The result sits in an output register, so the next word is accepted and
// worked on while the receiver stalls; only its final hand-off waits.
// Reset empties the queue (length 0, head pointer 0); memory contents are
// not cleared and need no clearing pass, as only occupied entries are read.
module tagged_deque_with_positional_remove import tdq_pkg::*; #(
	parameter int DEPTH  = 256,
	parameter int DATA_W = 32,
	parameter int ID_W   = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_word,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_word
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	tdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tdq_dp #(
		.DEPTH  (DEPTH),
		.DATA_W (DATA_W),
		.ID_W   (ID_W)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_word  (in_word),
		.cmd      (cmd),
		.sts      (sts),
		.out_word (out_word)
	);

endmodule

@@ rtl/core/tdq_dp.sv @@
// datapath: entry memory, head pointer, count, shift index and result register
module tdq_dp import tdq_pkg::*; #(
	parameter int DEPTH  = 256,
	parameter int DATA_W = 32,
	parameter int ID_W   = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  in_t     in_word,
	input  dp_cmd_t cmd,
	output dp_sts_t sts,
	output out_t    out_word
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = DATA_W + ID_W;

	logic [EW-1:0] mem_q [DEPTH];
	logic [EW-1:0] rdata_q;
	in_t           item_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic [1:0]    status_q;
	logic          rem_valid_q;
	logic [EW-1:0] rem_q;
	out_t          out_q;

	logic [AW-1:0] head_dec;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_word;
	logic [EW-1:0] item_word;
	logic [CW-1:0] pos_off;
	logic [CW-1:0] idx_next;
	logic [CW:0]   cnt_wide;
	logic          head_v;
	logic [DATA_W-1:0] rd_d;
	logic [ID_W-1:0]   rd_i;
	out_t          out_nxt;

	// circular slot of an offset from the head, sum stays below twice the depth
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
		input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW+1)'(base) + (CW+1)'(off);
		if (sum >= (CW+1)'(DEPTH)) begin
			sum = sum - (CW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign head_dec  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign item_word = {DATA_W'(item_q.item_data), ID_W'(item_q.item_id)};
	assign pos_off   = CW'(32'(item_q.position) - 32'd1);
	assign idx_next  = idx_q + CW'(1);
	assign cnt_wide  = (CW+1)'(cnt_q);
	assign rd_d      = rdata_q[EW-1:ID_W];
	assign rd_i      = rdata_q[ID_W-1:0];
	assign head_v    = (cnt_q != '0);

	always_comb begin
		case (cmd.rd_sel)
			RD_POS:   rd_addr = slot(head_q, pos_off);
			RD_SHIFT: rd_addr = slot(head_q, idx_next);
			default:  rd_addr = head_q;
		endcase
	end

	always_comb begin
		case (cmd.wr_sel)
			WR_TAIL: begin
				wr_addr = slot(head_q, cnt_q);
				wr_word = item_word;
			end
			WR_HEAD: begin
				wr_addr = head_dec;
				wr_word = item_word;
			end
			default: begin
				wr_addr = slot(head_q, idx_q);
				wr_word = rdata_q;
			end
		endcase
	end

	always_comb begin
		sts.func            = item_q.func;
		sts.full            = (cnt_q == CW'(DEPTH));
		sts.empty           = (cnt_q == '0);
		sts.pos_bad         = (item_q.position == '0)
			|| (32'(item_q.position) > 32'(cnt_q));
		sts.shift_more      = ((CW+1)'(idx_q) + (CW+1)'(1)) < cnt_wide;
		sts.shift_more_next = ((CW+1)'(idx_q) + (CW+1)'(2)) < cnt_wide;
	end

	always_comb begin
		out_nxt.status        = status_q;
		out_nxt.removed_valid = rem_valid_q;
		out_nxt.removed_data  = 32'(rem_q[EW-1:ID_W]);
		out_nxt.removed_id    = 16'(rem_q[ID_W-1:0]);
		out_nxt.head_valid    = head_v;
		out_nxt.head_data     = head_v ? 32'(rd_d) : 32'd0;
		out_nxt.head_id_match = head_v && (rd_i == ID_W'(item_q.item_id));
		out_nxt.length        = 9'(cnt_q);
	end

	// entry memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_sel != WR_NONE) begin
			mem_q[wr_addr] <= wr_word;
		end
		rdata_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
		end else begin
			case (cmd.head_op)
				HEAD_DEC:  head_q <= head_dec;
				HEAD_INC:  head_q <= slot(head_q, CW'(1));
				HEAD_ZERO: head_q <= '0;
				default:   head_q <= head_q;
			endcase
			case (cmd.cnt_op)
				CNT_INC:  cnt_q <= cnt_q + CW'(1);
				CNT_DEC:  cnt_q <= cnt_q - CW'(1);
				CNT_ZERO: cnt_q <= '0;
				default:  cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q      <= in_word;
			status_q    <= ST_OK;
			rem_valid_q <= 1'b0;
			rem_q       <= '0;
		end else begin
			if (cmd.set_status) begin
				status_q <= cmd.status;
			end
			if (cmd.cap_removed) begin
				rem_valid_q <= 1'b1;
				rem_q       <= rdata_q;
			end
		end
		if (cmd.idx_init) begin
			idx_q <= pos_off;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_next;
		end
		if (cmd.load_out) begin
			out_q <= out_nxt;
		end
	end

	assign out_word = out_q;

endmodule

@@ rtl/core/tdq_ctrl.sv @@
// controller: sequences each operation and owns the handshakes
module tdq_ctrl import tdq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_POP_CAP, S_REM_CAP, S_SHIFT_RD, S_SHIFT_WR, S_HEAD_RD, S_FINISH
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd             = '0;
		cmd.rd_sel      = RD_HEAD;
		cmd.wr_sel      = WR_NONE;
		cmd.head_op     = HEAD_KEEP;
		cmd.cnt_op      = CNT_KEEP;
		cmd.status      = ST_OK;
		state_nxt       = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.load_item = in_valid;
				if (in_valid) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				state_nxt = S_FINISH;
				case (sts.func)
					FN_PUSH_TAIL, FN_PUSH_HEAD: begin
						if (sts.full) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_FULL;
						end else begin
							cmd.cnt_op = CNT_INC;
							if (sts.func == FN_PUSH_TAIL) begin
								cmd.wr_sel = WR_TAIL;
							end else begin
								cmd.wr_sel  = WR_HEAD;
								cmd.head_op = HEAD_DEC;
							end
							state_nxt = S_HEAD_RD;
						end
					end
					FN_POP: begin
						if (sts.empty) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_EMPTY;
						end else begin
							state_nxt = S_POP_CAP;
						end
					end
					FN_REMOVE: begin
						if (sts.empty) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_EMPTY;
						end else if (sts.pos_bad) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_BADPOS;
						end else begin
							cmd.rd_sel   = RD_POS;
							cmd.idx_init = 1'b1;
							state_nxt    = S_REM_CAP;
						end
					end
					FN_CLEAR: begin
						cmd.cnt_op  = CNT_ZERO;
						cmd.head_op = HEAD_ZERO;
					end
					default: begin
						cmd.rd_sel = RD_HEAD;
					end
				endcase
			end
			S_POP_CAP: begin
				cmd.cap_removed = 1'b1;
				cmd.head_op     = HEAD_INC;
				cmd.cnt_op      = CNT_DEC;
				state_nxt       = S_HEAD_RD;
			end
			S_REM_CAP: begin
				cmd.cap_removed = 1'b1;
				cmd.rd_sel      = RD_SHIFT;
				if (sts.shift_more) begin
					state_nxt = S_SHIFT_WR;
				end else begin
					cmd.cnt_op = CNT_DEC;
					state_nxt  = S_HEAD_RD;
				end
			end
			S_SHIFT_RD: begin
				cmd.rd_sel = RD_SHIFT;
				state_nxt  = S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				// move the entry behind the gap one place toward the head
				cmd.wr_sel  = WR_SHIFT;
				cmd.idx_inc = 1'b1;
				if (sts.shift_more_next) begin
					state_nxt = S_SHIFT_RD;
				end else begin
					cmd.cnt_op = CNT_DEC;
					state_nxt  = S_HEAD_RD;
				end
			end
			S_HEAD_RD: begin
				state_nxt = S_FINISH;
			end
			S_FINISH: begin
				// head read stays pointed at the head while the result slot is busy
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/core/tdq_chk.sv @@
// port-level checker for the tagged deque, bound to the top level
`include "tagged_deque_with_positional_remove_assert.svh"

module tdq_chk import tdq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input out_t out_word
);

	`TDQ_ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_word), "result word changed while stalled")
	`TDQ_ASSERT_CLK(a_removed_ok, out_valid && out_word.removed_valid |-> out_word.status == ST_OK, "removal reported with error status")
	`TDQ_ASSERT_NEVER(a_match_no_head, out_valid && out_word.head_id_match && !out_word.head_valid, "id match without head")
	`TDQ_ASSERT_NEVER(a_empty_data, out_valid && !out_word.head_valid && out_word.head_data != 32'd0, "head data on empty queue")

endmodule

bind tagged_deque_with_positional_remove tdq_chk u_tdq_chk (.*);
